// ===== rtl/core/sit_pkg.sv =====
// Shared types and constants for the system interface / interrupt timer block.
// No dependencies; compiled first.
package sit_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_LINE  = 2'd2,
    FUNC_TICK  = 2'd3
  } sit_func_e;

  // Read byte selects
  typedef enum logic [1:0] {
    BYTE_INT_LO  = 2'd0,
    BYTE_INT_HI  = 2'd1,
    BYTE_PORT_LO = 2'd2,
    BYTE_PORT_HI = 2'd3
  } sit_byte_e;

  localparam int unsigned NumLines = 16;
  localparam int unsigned CntW     = 14;

  localparam logic [15:0] SuppMaskRst = 16'h0006;
  localparam logic [3:0]  TimerLine   = 4'd3;   // line replaced by the timer
  localparam logic [3:0]  SoftRstBit  = 4'd15;  // bit 15 write: enable 15 / soft reset
  localparam logic [3:0]  MirrorFirst = 4'd7;   // first mirrored port pin
  localparam logic [4:0]  MirrorBase  = 5'd22;  // pin p mirrors onto line 22-p

  // Result payload
  typedef struct packed {
    logic [7:0]  read_data;
    logic        int_request;
    logic [15:0] port_direction;
    logic [15:0] port_output;
  } sit_rsp_t;

endpackage

// ===== rtl/core/sit_if.sv =====
// Valid/ready channel interfaces for the request and result beats.
// Depends on nothing; compiled after sit_pkg.
interface sit_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [4:0]  offset;
  logic        data;
  logic [15:0] ext_int_pins;
  logic [15:0] ext_port_pins;

  modport source (output valid, func, offset, data, ext_int_pins, ext_port_pins,
                  input ready);
  modport sink   (input valid, func, offset, data, ext_int_pins, ext_port_pins,
                  output ready);
endinterface

interface sit_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        int_request;
  logic [15:0] port_direction;
  logic [15:0] port_output;

  modport source (output valid, read_data, int_request, port_direction, port_output,
                  input ready);
  modport sink   (input valid, read_data, int_request, port_direction, port_output,
                  output ready);
endinterface

// ===== rtl/core/system_interface_irq_timer.sv =====
// System interface peripheral: interrupt controller, 14-bit decrementer, 16 port pins.
// Depends on sit_pkg and the channel interfaces in sit_if.sv.
//
// One request beat in per cycle unless a stalled consumer holds the flow, one result
// beat out per request. A beat lands in the input register at its accepting edge; the
// decode/update logic then commits all state and loads the result register once
// it is empty or being taken. Sustained throughput is one beat per clock while the
// consumer takes every result. The two registers advance together whenever the result
// register is empty or being taken, so a stalled consumer holds both without losing a
// beat. The external-line mask (lines driven from outside, read back inverted) resets
// to 6 and is written through cfg_we_i/cfg_wdata_i; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module system_interface_irq_timer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  sit_req_if.sink       req_i,
  sit_rsp_if.source     rsp_o
);

  localparam int unsigned CW = sit_pkg::CntW;

  // ---------------------------------------------------------------- config
  logic [15:0] supp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supp_q <= sit_pkg::SuppMaskRst;
    end else if (cfg_we_i) begin
      supp_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- handshake
  logic in_vld_q, rsp_vld_q;
  logic advance;   // input register drains into result register

  assign advance     = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = !in_vld_q || advance;

  // input register (payload holds no reset)
  logic [1:0]  func_q;
  logic [4:0]  off_q;
  logic        dat_q;
  logic [15:0] eint_q, eport_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q  <= req_i.func;
      off_q   <= req_i.offset;
      dat_q   <= req_i.data;
      eint_q  <= req_i.ext_int_pins;
      eport_q <= req_i.ext_port_pins;
    end
  end

  // ---------------------------------------------------------------- state
  logic          mode_q,  mode_d;     // 1 = timer mode
  logic [CW-1:0] ivl_q,   ivl_d;      // clock interval
  logic          chg_q,   chg_d;      // interval written in timer mode
  logic [CW-1:0] dec_q,   dec_d;      // decrementer
  logic [CW-1:0] lat_q,   lat_d;      // latched count
  logic          tpnd_q,  tpnd_d;     // timer interrupt pending
  logic [15:0]   lines_q, lines_d;
  logic [15:0]   en_q,    en_d;
  logic          irq_q,   irq_d;
  logic [15:0]   dir_q,   dir_d;
  logic [15:0]   out_q,   out_d;
  logic [15:0]   mdir_q,  mdir_d;
  logic [15:0]   mout_q,  mout_d;
  logic [7:0]    rd_d;

  // derived indices
  logic [3:0] ivl_bit;   // interval bit for write offsets 1..14
  logic [3:0] pin;       // port pin for write offsets 16..31
  logic [3:0] mline;     // interrupt line mirrored by that pin
  logic [15:0] int_rd;   // interrupt pin view for I/O-mode reads
  logic [15:0] port_rd;  // port pin view
  logic [15:0] act;      // active lines for the request

  assign ivl_bit = off_q[3:0] - 4'd1;
  assign pin     = off_q[3:0];
  assign mline   = 4'(sit_pkg::MirrorBase - {1'b0, pin});
  assign int_rd  = (((~lines_q & supp_q) | eint_q) & ~mdir_q) | (mout_q & mdir_q);
  assign port_rd = (eport_q & ~dir_q) | (out_q & dir_q);

  always_comb begin
    mode_d  = mode_q;
    ivl_d   = ivl_q;
    chg_d   = chg_q;
    dec_d   = dec_q;
    lat_d   = lat_q;
    tpnd_d  = tpnd_q;
    lines_d = lines_q;
    en_d    = en_q;
    dir_d   = dir_q;
    out_d   = out_q;
    mdir_d  = mdir_q;
    mout_d  = mout_q;
    rd_d    = 8'h00;

    case (sit_pkg::sit_func_e'(func_q))
      sit_pkg::FUNC_READ: begin
        unique case (sit_pkg::sit_byte_e'(off_q[1:0]))
          sit_pkg::BYTE_INT_LO: begin
            rd_d = mode_q ? {lat_q[6:0], 1'b1} : int_rd[7:0];
          end
          sit_pkg::BYTE_INT_HI: begin
            // timer mode: bit 7 is the request before this beat, inverted
            rd_d = mode_q ? {~irq_q, lat_q[13:7]} : int_rd[15:8];
          end
          sit_pkg::BYTE_PORT_LO: begin
            rd_d = port_rd[7:0];
            if (mode_q) begin
              mode_d = 1'b0;
              if (chg_q) dec_d = ivl_q;
            end
          end
          default: begin
            rd_d = port_rd[15:8];
            if (mode_q) begin
              mode_d = 1'b0;
              if (chg_q) dec_d = ivl_q;
            end
          end
        endcase
      end

      sit_pkg::FUNC_WRITE: begin
        if (off_q == 5'd0) begin
          // mode bit
          if (dat_q && !mode_q) begin
            mode_d = 1'b1;
            lat_d  = (ivl_q != '0) ? dec_q : '0;
            chg_d  = 1'b0;
          end else if (!dat_q && mode_q) begin
            mode_d = 1'b0;
            if (chg_q) dec_d = ivl_q;
          end
        end else if (!off_q[4] && off_q[3:0] != sit_pkg::SoftRstBit) begin
          if (mode_q) begin
            ivl_d[ivl_bit] = dat_q;
            chg_d          = 1'b1;
          end else begin
            en_d[off_q[3:0]] = dat_q;
            if (off_q[3:0] == sit_pkg::TimerLine) tpnd_d = 1'b0;
          end
        end else if (!off_q[4]) begin
          if (mode_q) begin
            if (!dat_q) begin   // soft reset
              dir_d  = '0;
              mdir_d = '0;
            end
          end else begin
            en_d[sit_pkg::SoftRstBit] = dat_q;
          end
        end else begin
          // port pin write, leaves timer mode
          if (mode_q) begin
            mode_d = 1'b0;
            if (chg_q) dec_d = ivl_q;
          end
          dir_d[pin] = 1'b1;
          out_d[pin] = dat_q;
          if (pin >= sit_pkg::MirrorFirst) begin
            mdir_d[mline] = 1'b1;
            mout_d[mline] = dat_q;
          end
        end
      end

      sit_pkg::FUNC_LINE: begin
        if (!off_q[4]) lines_d[off_q[3:0]] = dat_q;
      end

      default: begin
        if (ivl_q != '0) begin
          if (dec_q <= CW'(1)) begin
            dec_d  = ivl_q;
            tpnd_d = 1'b1;
          end else begin
            dec_d = dec_q - CW'(1);
          end
        end
      end
    endcase

    act = lines_d;
    if (ivl_d != '0) act[sit_pkg::TimerLine] = tpnd_d;
    irq_d = |(act & en_d & ~mdir_d);
  end

  logic commit;
  assign commit = in_vld_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      ivl_q   <= '0;
      chg_q   <= 1'b0;
      dec_q   <= '0;
      lat_q   <= '0;
      tpnd_q  <= 1'b0;
      lines_q <= '0;
      en_q    <= '0;
      irq_q   <= 1'b0;
      dir_q   <= '0;
      out_q   <= '0;
      mdir_q  <= '0;
      mout_q  <= '0;
    end else if (commit) begin
      mode_q  <= mode_d;
      ivl_q   <= ivl_d;
      chg_q   <= chg_d;
      dec_q   <= dec_d;
      lat_q   <= lat_d;
      tpnd_q  <= tpnd_d;
      lines_q <= lines_d;
      en_q    <= en_d;
      irq_q   <= irq_d;
      dir_q   <= dir_d;
      out_q   <= out_d;
      mdir_q  <= mdir_d;
      mout_q  <= mout_d;
    end
  end

  // ---------------------------------------------------------------- result register
  sit_pkg::sit_rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_q.read_data      <= rd_d;
      rsp_q.int_request    <= irq_d;
      rsp_q.port_direction <= dir_d;
      rsp_q.port_output    <= out_d & dir_d;
    end
  end

  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.read_data      = rsp_q.read_data;
  assign rsp_o.int_request    = rsp_q.int_request;
  assign rsp_o.port_direction = rsp_q.port_direction;
  assign rsp_o.port_output    = rsp_q.port_output;

endmodule
